@@ rtl/core/fshx_pkg.sv @@
// ----------------------------------------------------------------------------
// fshx_pkg
// Shared widths, character codes, control structs and the hex digit mapping
// for the format string hex expander.
// ----------------------------------------------------------------------------
package fshx_pkg;

  localparam int CHAR_W  = 8;
  localparam int ARG_W   = 32;
  localparam int DIGIT_W = 4;
  localparam int NDIGITS = ARG_W / DIGIT_W;
  localparam int DCNT_W  = $clog2(NDIGITS);
  localparam int LEN_W   = 11;

  localparam logic [LEN_W-1:0] MAX_LENGTH = LEN_W'(1024);

  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A       = 8'h41;
  localparam logic [DIGIT_W-1:0] DEC_RADIX   = 4'd10;

  typedef struct packed {
    logic load;
    logic shift;
  } hexser_ctl_t;

  typedef struct packed {
    logic              lead_zero;
    logic              last_digit;
    logic [CHAR_W-1:0] digit_char;
  } hexser_stat_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < DEC_RADIX) begin
      return CHAR_ZERO + dx;
    end else begin
      return CHAR_A + dx - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_RADIX};
    end
  endfunction

endpackage

@@ rtl/core/fshx_if.sv @@
// ----------------------------------------------------------------------------
// fshx channel interfaces
// Valid/ready channels for format characters in and expanded characters out.
// ----------------------------------------------------------------------------
interface fshx_in_if;
  logic                        valid;
  logic                        ready;
  logic [fshx_pkg::CHAR_W-1:0] fmt_char;
  logic [fshx_pkg::ARG_W-1:0]  arg_value;

  modport source (output valid, output fmt_char, output arg_value, input ready);
  modport sink   (input valid, input fmt_char, input arg_value, output ready);
endinterface

interface fshx_out_if;
  logic                        valid;
  logic                        ready;
  logic [fshx_pkg::CHAR_W-1:0] out_char;
  logic                        last;
  logic [fshx_pkg::LEN_W-1:0]  total_length;

  modport source (output valid, output out_char, output last, output total_length,
                  input ready);
  modport sink   (input valid, input out_char, input last, input total_length,
                  output ready);
endinterface

@@ rtl/core/fshx_hex_ser.sv @@
// ----------------------------------------------------------------------------
// fshx_hex_ser
// Nibble shift register for the argument: one hex digit per shift, most
// significant first, with leading zero suppression down to the last digit.
// ----------------------------------------------------------------------------
module fshx_hex_ser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fshx_pkg::hexser_ctl_t       ctl,
  input  logic [fshx_pkg::ARG_W-1:0]  arg_value,
  output fshx_pkg::hexser_stat_t      stat
);

  logic [fshx_pkg::ARG_W-1:0]  sr_r, sr_nxt;
  logic [fshx_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic                        skip_r, skip_nxt;
  logic [fshx_pkg::DIGIT_W-1:0] top_digit;

  assign top_digit = sr_r[fshx_pkg::ARG_W-1 -: fshx_pkg::DIGIT_W];

  always_comb begin
    stat.lead_zero  = skip_r && (top_digit == '0) && (dcnt_r != '0);
    stat.last_digit = (dcnt_r == '0);
    stat.digit_char = fshx_pkg::hex_char(top_digit);
  end

  always_comb begin
    sr_nxt   = sr_r;
    dcnt_nxt = dcnt_r;
    skip_nxt = skip_r;
    if (ctl.load) begin
      sr_nxt   = arg_value;
      dcnt_nxt = fshx_pkg::DCNT_W'(fshx_pkg::NDIGITS - 1);
      skip_nxt = 1'b1;
    end else if (ctl.shift) begin
      sr_nxt   = {sr_r[fshx_pkg::ARG_W-fshx_pkg::DIGIT_W-1:0], {fshx_pkg::DIGIT_W{1'b0}}};
      dcnt_nxt = dcnt_r - 1'b1;
      // once a digit goes out, zeros are printed
      skip_nxt = stat.lead_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
      skip_r <= 1'b0;
    end else begin
      dcnt_r <= dcnt_nxt;
      skip_r <= skip_nxt;
    end
    sr_r <= sr_nxt;
  end

endmodule

@@ rtl/core/format_string_hex_expander.sv @@
// ----------------------------------------------------------------------------
// format_string_hex_expander
// Minimal printf for "%x": copies format characters, expands %x arguments
// to upper-case hex and reports the string length on the terminator.
// ----------------------------------------------------------------------------
// One format character enters per item. A plain character or a terminator
// yields one result from the work stage; the next item is taken in that
// same cycle, so an unstalled stream runs at one item per cycle.
// A '%' yields nothing and leaves the block ready. A %x conversion always
// shifts the nibble shift register once per hex digit of the 32-bit
// argument, suppressing leading zeros or sending one digit to the output
// register each cycle, holding a digit while the result side stalls. The
// output register lets a result wait while the work stage moves on.
module format_string_hex_expander (
  input  logic         clk,
  input  logic         rst_n,
  fshx_in_if.sink      in_ch,
  fshx_out_if.source   out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COPY = 2'd1;
  localparam logic [1:0] ST_HEX  = 2'd2;
  localparam logic [1:0] ST_TERM = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic                        pending_r, pending_nxt;
  logic [fshx_pkg::LEN_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [fshx_pkg::CHAR_W-1:0] char_r, char_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [fshx_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                        out_last_r, out_last_nxt;
  logic [fshx_pkg::LEN_W-1:0]  out_len_r, out_len_nxt;

  fshx_pkg::hexser_ctl_t  ser_ctl;
  fshx_pkg::hexser_stat_t ser_stat;

  logic in_fire, out_free, emit, step_fin;
  logic [1:0] dec_state;

  fshx_hex_ser u_hex_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ser_ctl),
    .arg_value (in_ch.arg_value),
    .stat      (ser_stat)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = (state_r != ST_IDLE) && !(state_r == ST_HEX && ser_stat.lead_zero)
                    && out_free;
  assign step_fin = emit && ((state_r != ST_HEX) || ser_stat.last_digit);
  assign in_ch.ready = (state_r == ST_IDLE) || step_fin;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign cnt_inc = (cnt_r < fshx_pkg::MAX_LENGTH) ? cnt_r + 1'b1 : cnt_r;

  // decode of the incoming character
  always_comb begin
    if (in_ch.fmt_char == fshx_pkg::CHAR_NUL) begin
      dec_state = ST_TERM;
    end else if (in_ch.fmt_char == fshx_pkg::CHAR_PERCENT) begin
      dec_state = ST_IDLE;
    end else if (pending_r && in_ch.fmt_char == fshx_pkg::CHAR_X) begin
      dec_state = ST_HEX;
    end else begin
      dec_state = ST_COPY;
    end
  end

  always_comb begin
    ser_ctl.load  = in_fire && (dec_state == ST_HEX);
    ser_ctl.shift = (state_r == ST_HEX) && (ser_stat.lead_zero || emit);
  end

  always_comb begin
    state_nxt   = state_r;
    pending_nxt = pending_r;
    char_nxt    = char_r;
    if (step_fin) begin
      state_nxt = ST_IDLE;
    end
    if (in_fire) begin
      state_nxt   = dec_state;
      pending_nxt = (in_ch.fmt_char == fshx_pkg::CHAR_PERCENT);
      char_nxt    = in_ch.fmt_char;
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      case (state_r)
        ST_TERM: begin
          out_char_nxt = fshx_pkg::CHAR_NUL;
          out_last_nxt = 1'b1;
          out_len_nxt  = cnt_r;
          cnt_nxt      = '0;
        end
        ST_HEX: begin
          out_char_nxt = ser_stat.digit_char;
          out_last_nxt = ser_stat.last_digit;
          out_len_nxt  = cnt_inc;
          cnt_nxt      = cnt_inc;
        end
        default: begin
          out_char_nxt = char_r;
          out_last_nxt = 1'b1;
          out_len_nxt  = cnt_inc;
          cnt_nxt      = cnt_inc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pending_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    char_r     <= char_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_char     = out_char_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.total_length = out_len_r;

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= fshx_pkg::MAX_LENGTH)
    else $error("written count above limit");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit && state_r == ST_TERM |=> cnt_r == '0)
    else $error("count not cleared after terminator");

  a_hex_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HEX && !ser_stat.last_digit |-> !in_ch.ready)
    else $error("input taken during hex conversion");

  a_percent_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.fmt_char == fshx_pkg::CHAR_PERCENT |=> state_r == ST_IDLE && pending_r)
    else $error("percent started work");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the format string hex expander. Format bytes with
// arguments go in through a queued valid/ready driver. Each accepted byte is
// expanded by a behavioral predictor into the characters it should produce.
// A monitor compares every result with the oldest predicted character, field
// by field. The run covers directed corner cases, random strings under
// changing back-pressure, a long receiver hold-off, and one overlong string
// that saturates the length count.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned MAX_SHOWN    = 10;

  typedef struct packed {
    logic [fshx_pkg::CHAR_W-1:0] fmt_char;
    logic [fshx_pkg::ARG_W-1:0]  arg_value;
  } fmt_byte_t;

  typedef struct packed {
    logic [fshx_pkg::CHAR_W-1:0] out_char;
    logic                        last;
    logic [fshx_pkg::LEN_W-1:0]  total_length;
  } emitted_char_t;

  logic clk;
  logic rst_n;

  fshx_in_if  fmt_in ();
  fshx_out_if chars_out ();

  format_string_hex_expander dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (fmt_in),
    .out_ch (chars_out)
  );

  fmt_byte_t     fmt_bytes[$];
  emitted_char_t predicted_chars[$];

  // predictor state
  logic                       pct_armed = 1'b0;
  logic [fshx_pkg::LEN_W-1:0] char_count = '0;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned items_queued = 0;
  int unsigned error_count = 0;
  logic        item_taken;
  logic        hold_go;
  logic        hold_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_char(input logic [fshx_pkg::CHAR_W-1:0] ch,
                                    input logic last);
    emitted_char_t e;
    e.out_char     = ch;
    e.last         = last;
    e.total_length = char_count;
    predicted_chars.push_back(e);
  endfunction

  function automatic void expand_format_char(input logic [fshx_pkg::CHAR_W-1:0] ch,
                                             input logic [fshx_pkg::ARG_W-1:0]  arg);
    int                           top;
    logic [fshx_pkg::DIGIT_W-1:0] nib;
    logic [fshx_pkg::CHAR_W-1:0]  digit_code;
    if (ch == fshx_pkg::CHAR_NUL) begin
      pct_armed = 1'b0;
      push_char(fshx_pkg::CHAR_NUL, 1'b1);
      char_count = '0;
    end else if (ch == fshx_pkg::CHAR_PERCENT) begin
      pct_armed = 1'b1;
    end else if (pct_armed && ch == fshx_pkg::CHAR_X) begin
      pct_armed = 1'b0;
      top = fshx_pkg::NDIGITS - 1;
      // skip leading zero digits, but always keep the last one
      while (top > 0 && arg[fshx_pkg::DIGIT_W*top +: fshx_pkg::DIGIT_W] == '0) top--;
      for (int i = top; i >= 0; i--) begin
        nib = arg[fshx_pkg::DIGIT_W*i +: fshx_pkg::DIGIT_W];
        if (nib < fshx_pkg::DEC_RADIX) begin
          digit_code = fshx_pkg::CHAR_ZERO + fshx_pkg::CHAR_W'(nib);
        end else begin
          digit_code = fshx_pkg::CHAR_A + fshx_pkg::CHAR_W'(nib - fshx_pkg::DEC_RADIX);
        end
        if (char_count < fshx_pkg::MAX_LENGTH) char_count++;
        push_char(digit_code, i == 0);
      end
    end else begin
      pct_armed = 1'b0;
      if (char_count < fshx_pkg::MAX_LENGTH) char_count++;
      push_char(ch, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------- driver / sink

  always @(posedge clk) begin
    item_taken = rst_n && fmt_in.valid && fmt_in.ready;
    if (item_taken) begin
      expand_format_char(fmt_in.fmt_char, fmt_in.arg_value);
      void'(fmt_bytes.pop_front());
    end
  end

  always @(negedge clk) begin
    logic offer;
    if (!rst_n) begin
      offer = 1'b0;
    end else if (fmt_in.valid && !item_taken) begin
      offer = 1'b1;  // keep the item up until it is accepted
    end else begin
      offer = (fmt_bytes.size() != 0) && ($urandom_range(0, 99) >= src_idle_pct);
    end
    fmt_in.valid <= offer;
    if (offer) begin
      fmt_in.fmt_char  <= fmt_bytes[0].fmt_char;
      fmt_in.arg_value <= fmt_bytes[0].arg_value;
    end
  end

  always @(negedge clk) begin
    chars_out.ready <= !hold_on && ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    hold_on = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // ---------------------------------------------------------------- monitor

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    emitted_char_t want;
    if (rst_n && chars_out.valid && chars_out.ready) begin
      if (predicted_chars.size() == 0) begin
        note_error($sformatf("unexpected char %h last %b len %0d",
                             chars_out.out_char, chars_out.last,
                             chars_out.total_length));
      end else begin
        want = predicted_chars.pop_front();
        if (chars_out.out_char !== want.out_char || chars_out.last !== want.last ||
            chars_out.total_length !== want.total_length) begin
          note_error($sformatf("exp char %h last %b len %0d, got char %h last %b len %0d",
                               want.out_char, want.last, want.total_length,
                               chars_out.out_char, chars_out.last,
                               chars_out.total_length));
        end
      end
    end
  end

  // --------------------------------------------------------------- stimulus

  function automatic void add_item(input logic [fshx_pkg::CHAR_W-1:0] ch,
                                   input logic [fshx_pkg::ARG_W-1:0]  arg);
    fmt_byte_t b;
    b.fmt_char  = ch;
    b.arg_value = arg;
    fmt_bytes.push_back(b);
    items_queued++;
  endfunction

  function automatic logic [fshx_pkg::ARG_W-1:0] pick_arg();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom >> (fshx_pkg::DIGIT_W *
                                   $urandom_range(0, fshx_pkg::NDIGITS - 1));
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_random_strings(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    start = items_queued;
    while (items_queued - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        add_item(fshx_pkg::CHAR_W'($urandom_range(1, 255)), $urandom);
      end else if (pick < 65) begin
        add_item(fshx_pkg::CHAR_PERCENT, $urandom);
        add_item(fshx_pkg::CHAR_X, pick_arg());
      end else if (pick < 75) begin
        add_item(fshx_pkg::CHAR_PERCENT, $urandom);
        add_item(fshx_pkg::CHAR_W'($urandom_range(1, 255)), pick_arg());
      end else if (pick < 82) begin
        add_item(fshx_pkg::CHAR_PERCENT, $urandom);
        add_item(fshx_pkg::CHAR_PERCENT, $urandom);
        add_item(fshx_pkg::CHAR_X, pick_arg());
      end else if (pick < 92) begin
        add_item(fshx_pkg::CHAR_NUL, $urandom);
      end else begin
        add_item(fshx_pkg::CHAR_W'($urandom), $urandom);
      end
    end
    add_item(fshx_pkg::CHAR_NUL, $urandom);
  endfunction

  task automatic wait_drained();
    while (fmt_bytes.size() != 0 || predicted_chars.size() != 0) @(posedge clk);
  endtask

  initial begin
    src_idle_pct = 32;
    snk_idle_pct = 64;
    hold_go      = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // directed corners
    add_item(8'h41, 32'h0000_0000);
    add_item(8'hFF, 32'hFFFF_FFFF);
    add_item(8'h01, 32'h5555_5555);
    add_item(fshx_pkg::CHAR_X, 32'hAAAA_AAAA);      // x without a percent is plain
    add_item(fshx_pkg::CHAR_PERCENT, 32'h0);
    add_item(fshx_pkg::CHAR_X, 32'h0000_0000);      // zero argument prints one digit
    add_item(fshx_pkg::CHAR_PERCENT, 32'h0);
    add_item(fshx_pkg::CHAR_X, 32'hFFFF_FFFF);
    add_item(fshx_pkg::CHAR_PERCENT, 32'h0);
    add_item(fshx_pkg::CHAR_X, 32'h8000_0000);
    add_item(fshx_pkg::CHAR_PERCENT, 32'h0);
    add_item(fshx_pkg::CHAR_X, 32'h0000_000F);
    add_item(fshx_pkg::CHAR_PERCENT, 32'h0);
    add_item(8'h64, 32'h1234_5678);                 // other letter after percent
    add_item(fshx_pkg::CHAR_PERCENT, 32'h0);
    add_item(fshx_pkg::CHAR_PERCENT, 32'h0);        // double percent stays armed
    add_item(fshx_pkg::CHAR_X, 32'h0A1B_2C3D);
    add_item(fshx_pkg::CHAR_NUL, 32'hDEAD_BEEF);
    add_item(fshx_pkg::CHAR_PERCENT, 32'h0);
    add_item(fshx_pkg::CHAR_NUL, 32'h0);            // terminator while armed
    add_item(8'h7E, 32'h0);
    add_item(fshx_pkg::CHAR_PERCENT, 32'h0);
    add_item(fshx_pkg::CHAR_X, 32'h0001_2345);
    add_item(fshx_pkg::CHAR_NUL, 32'h0);
    wait_drained();

    queue_random_strings(30);
    wait_drained();

    src_idle_pct = 64;
    snk_idle_pct = 32;
    queue_random_strings(30);
    wait_drained();

    // one overlong string to saturate the length, under a receiver hold-off
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (int k = 0; k < 130; k++) begin
      add_item(fshx_pkg::CHAR_PERCENT, $urandom);
      add_item(fshx_pkg::CHAR_X, $urandom | 32'h1000_0000);
    end
    add_item(fshx_pkg::CHAR_NUL, $urandom);
    add_item(8'h5A, $urandom);            // count starts over after the terminator
    add_item(fshx_pkg::CHAR_NUL, $urandom);
    hold_go = 1'b1;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
